// ===== sv/load_store_unit_assert.svh =====
`ifndef LOAD_STORE_UNIT_ASSERT_SVH
`define LOAD_STORE_UNIT_ASSERT_SVH

// Clocked assertion that is checked only outside reset.
`define LSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define LSU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== sv/lsu_pkg.sv =====
`timescale 1ns / 1ps

package lsu_pkg;

    // Request kinds carried in the input tuser.
    typedef enum logic [2:0] {
        REQ_LB = 3'd0,
        REQ_LH = 3'd1,
        REQ_LW = 3'd2,
        REQ_SB = 3'd3,
        REQ_SH = 3'd4,
        REQ_SW = 3'd5,
        REQ_RSVD6 = 3'd6,
        REQ_RSVD7 = 3'd7
    } req_type_t;

    // Result status codes carried in the output tuser.
    typedef enum logic [1:0] {
        STATUS_OK = 2'd0,
        STATUS_MISALIGNED = 2'd1,
        STATUS_OUT_OF_WINDOW = 2'd2,
        STATUS_RSVD = 2'd3
    } status_t;

    // Configuration register indexes.
    localparam logic CFG_WINDOW_START = 1'b0;
    localparam logic CFG_WINDOW_END = 1'b1;

    localparam logic signed [31:0] WINDOW_START_RESET = 32'sd0;
    localparam logic signed [31:0] WINDOW_END_RESET = 32'sd65536;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ACCESS,
        S_FORMAT,
        S_RESP
    } lsu_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic check;
        logic access;
        logic format;
    } lsu_cmd_t;

    // Access size in bytes (1, 2 or 4) for a request kind.
    function automatic logic [2:0] access_bytes(input logic [2:0] kind);
        logic [2:0] n;
        case (kind)
            REQ_LB, REQ_SB: n = 3'd1;
            REQ_LH, REQ_SH: n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

endpackage

// ===== sv/lsu_ctrl.sv =====
`timescale 1ns / 1ps
`include "load_store_unit_assert.svh"

module lsu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output lsu_pkg::lsu_cmd_t cmd
);

    lsu_pkg::lsu_state_t state_reg;
    lsu_pkg::lsu_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsu_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        cmd = '0;
        unique case (state_reg)
            lsu_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next = lsu_pkg::S_CHECK;
                end
            end
            lsu_pkg::S_CHECK: begin
                cmd.check = 1'b1;
                state_next = lsu_pkg::S_ACCESS;
            end
            lsu_pkg::S_ACCESS: begin
                cmd.access = 1'b1;
                state_next = lsu_pkg::S_FORMAT;
            end
            lsu_pkg::S_FORMAT: begin
                cmd.format = 1'b1;
                state_next = lsu_pkg::S_RESP;
            end
            lsu_pkg::S_RESP: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = lsu_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = lsu_pkg::S_IDLE;
            end
        endcase
    end

    `LSU_ASSERT(a_one_side_open, !(s_tready && m_tvalid), "input and output open together")
    `LSU_ASSERT(a_result_after_four, (s_tvalid && s_tready) |-> ##4 m_tvalid, "result not on time")

endmodule

// ===== sv/lsu_datapath.sv =====
`timescale 1ns / 1ps
`include "load_store_unit_assert.svh"

module lsu_datapath #(
    parameter int MEM_BYTES = 65536
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lsu_pkg::lsu_cmd_t cmd,
    input  logic [2:0]        req_type,
    input  logic [31:0]       address,
    input  logic [31:0]       store_value,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_wr_data,
    output logic [31:0]       load_data,
    output logic [1:0]        status
);

    localparam int OFF_W = $clog2(MEM_BYTES);
    localparam int IDX_W = OFF_W + 1;
    localparam int ROWS = (MEM_BYTES + 3) / 4;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic signed [31:0] win_start_reg;
    logic signed [31:0] win_end_reg;

    logic [2:0]  type_reg;
    logic [31:0] addr_reg;
    logic [31:0] data_reg;
    logic [OFF_W-1:0] off_reg;
    logic [1:0]  stat_reg;
    logic [7:0]  rd_reg [4];
    logic [31:0] load_data_reg;
    logic [1:0]  status_reg;

    logic [2:0]  nbytes;
    logic        type_valid;
    logic        is_store;
    logic        access_ok;
    logic signed [33:0] addr_x;
    logic signed [33:0] last_x;
    logic signed [33:0] start_x;
    logic signed [33:0] end_x;
    logic signed [33:0] limit_x;
    logic signed [33:0] off_x;
    logic        misaligned;
    logic        out_of_window;
    logic [3:0]  lane_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_start_reg <= lsu_pkg::WINDOW_START_RESET;
            win_end_reg <= lsu_pkg::WINDOW_END_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lsu_pkg::CFG_WINDOW_START: win_start_reg <= cfg_wr_data;
                lsu_pkg::CFG_WINDOW_END:   win_end_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            type_reg <= req_type;
            addr_reg <= address;
            data_reg <= store_value;
        end
    end

    assign nbytes = lsu_pkg::access_bytes(type_reg);
    assign type_valid = (type_reg <= 3'(lsu_pkg::REQ_SW));
    assign is_store = (type_reg >= 3'(lsu_pkg::REQ_SB)) && type_valid;

    // Bounds are compared at 34 bits so that no sum can wrap.
    assign addr_x = 34'(signed'(addr_reg));
    assign start_x = 34'(win_start_reg);
    assign end_x = 34'(win_end_reg);
    assign last_x = addr_x + 34'(nbytes) - 34'sd1;
    assign limit_x = start_x + 34'(MEM_BYTES);
    assign off_x = addr_x - start_x;
    assign misaligned = (addr_reg[2:0] & (nbytes - 3'd1)) != 3'd0;
    assign out_of_window = (addr_x < start_x) || (last_x >= end_x) || (last_x >= limit_x);

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            off_reg <= off_x[OFF_W-1:0];
            if (!type_valid) begin
                stat_reg <= lsu_pkg::STATUS_OK;
            end else if (misaligned) begin
                stat_reg <= lsu_pkg::STATUS_MISALIGNED;
            end else if (out_of_window) begin
                stat_reg <= lsu_pkg::STATUS_OUT_OF_WINDOW;
            end else begin
                stat_reg <= lsu_pkg::STATUS_OK;
            end
        end
    end

    assign access_ok = type_valid && (stat_reg == lsu_pkg::STATUS_OK);

    // Four byte lanes; lane j holds bytes whose window offset is j modulo 4.
    // An access that starts off a lane boundary uses the next row in the lower lanes.
    for (genvar j = 0; j < 4; j++) begin : g_lane
        logic [7:0]       lane_mem [ROWS];
        logic [1:0]       lane_pos;
        logic [IDX_W-1:0] lane_idx;
        logic [ROW_W-1:0] lane_row;

        assign lane_pos = 2'(j) - off_reg[1:0];
        assign lane_idx = {1'b0, off_reg} + IDX_W'(lane_pos);
        assign lane_row = lane_idx[ROW_W+1:2];
        assign lane_we[j] = cmd.access && is_store && access_ok
                            && ({1'b0, lane_pos} < nbytes);

        always_ff @(posedge aclk) begin
            if (lane_we[j]) begin
                lane_mem[lane_row] <= data_reg[8*lane_pos +: 8];
            end
            if (cmd.access) begin
                rd_reg[j] <= lane_mem[lane_row];
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic [31:0] word;
        logic [1:0]  lane;
        if (cmd.format) begin
            for (int i = 0; i < 4; i++) begin
                lane = off_reg[1:0] + 2'(i);
                word[8*i +: 8] = rd_reg[lane];
            end
            status_reg <= stat_reg;
            if (!access_ok || is_store) begin
                load_data_reg <= 32'd0;
            end else begin
                case (nbytes)
                    3'd1:    load_data_reg <= {{24{word[7]}}, word[7:0]};
                    3'd2:    load_data_reg <= {{16{word[15]}}, word[15:0]};
                    default: load_data_reg <= word;
                endcase
            end
        end
    end

    assign load_data = load_data_reg;
    assign status = status_reg;

    `LSU_ASSERT(a_write_only_ok, (lane_we != 4'd0) |-> (stat_reg == lsu_pkg::STATUS_OK), "memory written on a faulting request")
    `LSU_ASSERT(a_status_known, cmd.check |=> (stat_reg != lsu_pkg::STATUS_RSVD), "reserved status code")

endmodule

// ===== sv/load_store_unit.sv =====
`timescale 1ns / 1ps
// A result is presented once the request has passed the check, access and format states.
// The controller runs each request through check, memory access and format steps and
// takes the next one only after the result transaction completes.
// Reset (aresetn, synchronous, active low) clears the controller and loads the window
// registers with start 0 and end 65536; the byte memory is not cleared and needs no pass.
`include "load_store_unit_assert.svh"

module load_store_unit #(
    // Size of the backed memory in bytes.
    parameter int MEM_BYTES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Request channel. A transaction is taken when s_tvalid and s_tready are both high.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] address, [63:32] store_value
    input  logic [2:0]  s_tuser,    // [2:0] req_type

    // Result channel. One result transaction for every request.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] load_data
    output logic [1:0]  m_tuser,    // [1:0] status

    // Configuration writes: index 0 is window_start, index 1 is window_end.
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wr_data
);

    lsu_pkg::lsu_cmd_t cmd;

    // The controller steps one request through its phases and owns the handshakes.
    lsu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // The datapath holds the window registers, the alignment and bounds checks,
    // four byte-lane memories, and the output register that holds the result
    // until the result transaction completes.
    lsu_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .req_type    (s_tuser),
        .address     (s_tdata[31:0]),
        .store_value (s_tdata[63:32]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .load_data   (m_tdata),
        .status      (m_tuser)
    );

endmodule
